// ===== rtl/gbn_pkg.sv =====
package gbn_pkg;

  localparam int SEQ_W     = 3;
  localparam int PAYLOAD_W = 32;

  localparam logic [SEQ_W-1:0] MAX_SEQ = 3'd7;

  typedef enum logic [1:0] {
    CMD_NEW       = 2'd0,
    CMD_ARRIVE    = 2'd1,
    CMD_CKSUM_ERR = 2'd2,
    CMD_TIMEOUT   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_SENT    = 2'd0,
    KIND_ARRIVAL = 2'd1,
    KIND_REFUSED = 2'd2,
    KIND_NONE    = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t                kind;
    logic [SEQ_W-1:0]     frame_seq;
    logic [SEQ_W-1:0]     frame_ack;
    logic [PAYLOAD_W-1:0] frame_payload;
    logic                 delivered;
    logic [PAYLOAD_W-1:0] delivered_payload;
    logic [SEQ_W-1:0]     outstanding;
    logic                 network_ready;
    logic                 last;
  } result_t;

endpackage

// ===== rtl/gbn_send_store.sv =====
module gbn_send_store (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [gbn_pkg::SEQ_W-1:0]     wr_addr,
  input  logic [gbn_pkg::PAYLOAD_W-1:0] wr_data,
  input  logic                          rd_en,
  input  logic [gbn_pkg::SEQ_W-1:0]     rd_addr,
  output logic [gbn_pkg::PAYLOAD_W-1:0] rd_data
);
  import gbn_pkg::*;

  logic [PAYLOAD_W-1:0] mem [2**SEQ_W];
  logic [PAYLOAD_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/gbn_out_reg.sv =====
module gbn_out_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  gbn_pkg::result_t din,
  input  logic             out_stall,
  output logic             out_valid,
  output gbn_pkg::result_t dout,
  output logic             free
);
  import gbn_pkg::*;

  logic    valid_r;
  logic    valid_nxt;
  result_t data_r;

  assign free = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r && out_stall;
    if (load) begin
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= din;
    end
  end

  assign out_valid = valid_r;
  assign dout      = data_r;

endmodule

// ===== rtl/go_back_n_window_engine_core.sv =====
// A new packet, an arrival, a checksum error or an idle timeout gives its one result: the
// registered transaction is worked on in the execute state, which waits for a free output register.
// A timeout replay reads the send store once per frame, for up to 7 frames, passing through the
// read state and then the emit state per frame, since the store's read port is registered.
// One input transaction is worked on at a time; in_stall holds off the next one until idle.
// Synchronous active-low reset clears the window pointers and counters; the store is not cleared.
module go_back_n_window_engine_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_command,
  input  logic [gbn_pkg::PAYLOAD_W-1:0] in_payload,
  input  logic [gbn_pkg::SEQ_W-1:0]     in_rx_seq,
  input  logic [gbn_pkg::SEQ_W-1:0]     in_rx_ack,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_kind,
  output logic [gbn_pkg::SEQ_W-1:0]     out_frame_seq,
  output logic [gbn_pkg::SEQ_W-1:0]     out_frame_ack,
  output logic [gbn_pkg::PAYLOAD_W-1:0] out_frame_payload,
  output logic                          out_delivered,
  output logic [gbn_pkg::PAYLOAD_W-1:0] out_delivered_payload,
  output logic [gbn_pkg::SEQ_W-1:0]     out_outstanding,
  output logic                          out_network_ready,
  output logic                          out_last
);
  import gbn_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EXEC = 4'b0010,
    ST_READ = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  state_t               state_r, state_nxt;
  cmd_t                 cmd_r, cmd_nxt;
  logic [PAYLOAD_W-1:0] pay_r, pay_nxt;
  logic [SEQ_W-1:0]     rseq_r, rseq_nxt;
  logic [SEQ_W-1:0]     rack_r, rack_nxt;
  logic [SEQ_W-1:0]     nss_r, nss_nxt;
  logic [SEQ_W-1:0]     old_r, old_nxt;
  logic [SEQ_W-1:0]     exp_r, exp_nxt;
  logic [SEQ_W-1:0]     fo_r, fo_nxt;
  logic [SEQ_W-1:0]     ptr_r, ptr_nxt;
  logic [SEQ_W-1:0]     left_r, left_nxt;
  logic [SEQ_W-1:0]     ack_span;

  logic                 wr_en;
  logic                 rd_en;
  logic [PAYLOAD_W-1:0] rd_data;
  logic                 load;
  logic                 out_free;
  result_t              res;
  result_t              dout;

  gbn_send_store u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (nss_r),
    .wr_data (pay_r),
    .rd_en   (rd_en),
    .rd_addr (ptr_r),
    .rd_data (rd_data)
  );

  gbn_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .din       (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .dout      (dout),
    .free      (out_free)
  );

  assign in_stall = (state_r != ST_IDLE);
  assign ack_span = rack_r - old_r;

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    pay_nxt   = pay_r;
    rseq_nxt  = rseq_r;
    rack_nxt  = rack_r;
    nss_nxt   = nss_r;
    old_nxt   = old_r;
    exp_nxt   = exp_r;
    fo_nxt    = fo_r;
    ptr_nxt   = ptr_r;
    left_nxt  = left_r;
    wr_en     = 1'b0;
    rd_en     = 1'b0;
    load      = 1'b0;
    res       = '0;
    res.kind  = KIND_NONE;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = cmd_t'(in_command);
          pay_nxt   = in_payload;
          rseq_nxt  = in_rx_seq;
          rack_nxt  = in_rx_ack;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        unique case (cmd_r)
          CMD_NEW: begin
            if (out_free) begin
              load = 1'b1;
              if (fo_r == MAX_SEQ) begin
                res.kind = KIND_REFUSED;
              end else begin
                wr_en             = 1'b1;
                fo_nxt            = fo_r + 3'd1;
                nss_nxt           = nss_r + 3'd1;
                res.kind          = KIND_SENT;
                res.frame_seq     = nss_r;
                res.frame_ack     = exp_r - 3'd1;
                res.frame_payload = pay_r;
              end
              state_nxt = ST_IDLE;
            end
          end
          CMD_ARRIVE: begin
            if (out_free) begin
              load     = 1'b1;
              res.kind = KIND_ARRIVAL;
              if (rseq_r == exp_r) begin
                exp_nxt               = exp_r + 3'd1;
                res.delivered         = 1'b1;
                res.delivered_payload = pay_r;
              end
              if (fo_r != '0 && ack_span < fo_r) begin
                fo_nxt  = fo_r - ack_span - 3'd1;
                old_nxt = rack_r + 3'd1;
              end
              state_nxt = ST_IDLE;
            end
          end
          CMD_CKSUM_ERR: begin
            if (out_free) begin
              load      = 1'b1;
              state_nxt = ST_IDLE;
            end
          end
          CMD_TIMEOUT: begin
            if (fo_r == '0) begin
              if (out_free) begin
                load      = 1'b1;
                state_nxt = ST_IDLE;
              end
            end else begin
              ptr_nxt   = old_r;
              left_nxt  = fo_r;
              state_nxt = ST_READ;
            end
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end
      ST_READ: begin
        rd_en     = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          load              = 1'b1;
          res.kind          = KIND_SENT;
          res.frame_seq     = ptr_r;
          res.frame_ack     = exp_r - 3'd1;
          res.frame_payload = rd_data;
          ptr_nxt           = ptr_r + 3'd1;
          left_nxt          = left_r - 3'd1;
          if (left_r == 3'd1) begin
            nss_nxt   = ptr_r + 3'd1;
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_READ;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    res.outstanding   = fo_nxt;
    res.network_ready = (fo_nxt != MAX_SEQ);
    res.last          = (state_nxt == ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      nss_r   <= '0;
      old_r   <= '0;
      exp_r   <= '0;
      fo_r    <= '0;
    end else begin
      state_r <= state_nxt;
      nss_r   <= nss_nxt;
      old_r   <= old_nxt;
      exp_r   <= exp_nxt;
      fo_r    <= fo_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    pay_r  <= pay_nxt;
    rseq_r <= rseq_nxt;
    rack_r <= rack_nxt;
    ptr_r  <= ptr_nxt;
    left_r <= left_nxt;
  end

  assign out_kind              = dout.kind;
  assign out_frame_seq         = dout.frame_seq;
  assign out_frame_ack         = dout.frame_ack;
  assign out_frame_payload     = dout.frame_payload;
  assign out_delivered         = dout.delivered;
  assign out_delivered_payload = dout.delivered_payload;
  assign out_outstanding       = dout.outstanding;
  assign out_network_ready     = dout.network_ready;
  assign out_last              = dout.last;

endmodule

// ===== rtl/gbn_core_checker.sv =====
module gbn_core_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [1:0]                    out_kind,
  input logic [gbn_pkg::SEQ_W-1:0]     out_frame_seq,
  input logic [gbn_pkg::SEQ_W-1:0]     out_frame_ack,
  input logic [gbn_pkg::PAYLOAD_W-1:0] out_frame_payload,
  input logic                          out_delivered,
  input logic [gbn_pkg::PAYLOAD_W-1:0] out_delivered_payload,
  input logic [gbn_pkg::SEQ_W-1:0]     out_outstanding,
  input logic                          out_network_ready,
  input logic                          out_last
);
  import gbn_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind) && $stable(out_last)
      && $stable(out_frame_payload) && $stable(out_outstanding))
    else $error("Stalled result transaction changed.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("Input accepted while the previous transaction was still in work.");

  a_ready_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_network_ready == (out_outstanding != MAX_SEQ))
    else $error("Network ready disagrees with the outstanding count.");

  a_frame_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_SENT |-> out_frame_seq == '0 && out_frame_ack == '0
      && out_frame_payload == '0)
    else $error("Frame fields set on a result that sent no frame.");

  a_delivery_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_delivered |-> out_delivered_payload == '0)
    else $error("Delivered payload set without a delivery.");

endmodule

bind go_back_n_window_engine_core gbn_core_checker u_gbn_core_checker (.*);

// ===== tb/tb_go_back_n_window_engine_core.sv =====
`timescale 1ns / 100ps

module tb_go_back_n_window_engine_core;
  import gbn_pkg::*;

  localparam int RANDOM_ITEMS = 400;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    cmd_t                 cmd;
    logic [PAYLOAD_W-1:0] pay;
    logic [SEQ_W-1:0]     seq;
    logic [SEQ_W-1:0]     ack;
    bit                   typed;
    result_t              want;
  } stim_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [1:0]           in_command = 2'd0;
  logic [PAYLOAD_W-1:0] in_payload = '0;
  logic [SEQ_W-1:0]     in_rx_seq = '0;
  logic [SEQ_W-1:0]     in_rx_ack = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [1:0]           out_kind;
  logic [SEQ_W-1:0]     out_frame_seq;
  logic [SEQ_W-1:0]     out_frame_ack;
  logic [PAYLOAD_W-1:0] out_frame_payload;
  logic                 out_delivered;
  logic [PAYLOAD_W-1:0] out_delivered_payload;
  logic [SEQ_W-1:0]     out_outstanding;
  logic                 out_network_ready;
  logic                 out_last;

  logic [PAYLOAD_W-1:0] sent_copy [8];
  logic [SEQ_W-1:0]     next_seq_m = '0;
  logic [SEQ_W-1:0]     oldest_m = '0;
  logic [SEQ_W-1:0]     exp_rx_m = '0;
  logic [SEQ_W-1:0]     outst_m = '0;

  result_t   window_reports_q[$];
  result_t   step_reports[$];
  stim_row_t directed_rows[$];

  int          errors = 0;
  int          accepted_total = 0;
  int          checked_total = 0;
  int          replay_total = 0;
  int          refused_total = 0;
  int          delivered_total = 0;
  int          idle_cycles = 0;
  int unsigned rx_cycle = 0;
  int          stall_left = 0;
  bit          calm_tx = 1'b0;

  go_back_n_window_engine_core dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit ack_in_window(logic [SEQ_W-1:0] lo, logic [SEQ_W-1:0] a,
                                       logic [SEQ_W-1:0] hi);
    return ((lo <= a) && (a < hi)) || ((hi < lo) && (lo <= a)) || ((a < hi) && (hi < lo));
  endfunction

  function automatic result_t window_report(kind_t k, logic [SEQ_W-1:0] fseq,
                                            logic [PAYLOAD_W-1:0] fpay, logic dlv,
                                            logic [PAYLOAD_W-1:0] dpay, logic lst);
    result_t r;
    r = '0;
    r.kind = k;
    if (k == KIND_SENT) begin
      r.frame_seq     = fseq;
      r.frame_ack     = exp_rx_m - 3'd1;
      r.frame_payload = fpay;
    end
    r.delivered = dlv;
    if (dlv) begin
      r.delivered_payload = dpay;
    end
    r.outstanding   = outst_m;
    r.network_ready = (outst_m < MAX_SEQ);
    r.last          = lst;
    return r;
  endfunction

  function automatic result_t fixed_result(kind_t k, logic [SEQ_W-1:0] fseq,
                                           logic [SEQ_W-1:0] fack,
                                           logic [PAYLOAD_W-1:0] fpay, logic dlv,
                                           logic [PAYLOAD_W-1:0] dpay,
                                           logic [SEQ_W-1:0] outs, logic rdy);
    result_t r;
    r.kind              = k;
    r.frame_seq         = fseq;
    r.frame_ack         = fack;
    r.frame_payload     = fpay;
    r.delivered         = dlv;
    r.delivered_payload = dpay;
    r.outstanding       = outs;
    r.network_ready     = rdy;
    r.last              = 1'b1;
    return r;
  endfunction

  function automatic void predict_window(cmd_t c, logic [PAYLOAD_W-1:0] pay,
                                         logic [SEQ_W-1:0] rseq, logic [SEQ_W-1:0] rack);
    logic [SEQ_W-1:0] s;
    logic             dlv;
    int               n;
    int               i;
    step_reports.delete();
    case (c)
      CMD_NEW: begin
        if (outst_m >= MAX_SEQ) begin
          refused_total++;
          step_reports.push_back(window_report(KIND_REFUSED, '0, '0, 1'b0, '0, 1'b1));
        end else begin
          s = next_seq_m;
          sent_copy[s] = pay;
          outst_m = outst_m + 3'd1;
          next_seq_m = s + 3'd1;
          step_reports.push_back(window_report(KIND_SENT, s, pay, 1'b0, '0, 1'b1));
        end
      end
      CMD_ARRIVE: begin
        dlv = (rseq == exp_rx_m);
        if (dlv) begin
          exp_rx_m = exp_rx_m + 3'd1;
          delivered_total++;
        end
        while (outst_m != 0 && ack_in_window(oldest_m, rack, next_seq_m)) begin
          outst_m  = outst_m - 3'd1;
          oldest_m = oldest_m + 3'd1;
        end
        step_reports.push_back(window_report(KIND_ARRIVAL, '0, '0, dlv, pay, 1'b1));
      end
      CMD_TIMEOUT: begin
        if (outst_m != 0) begin
          n = outst_m;
          s = oldest_m;
          for (i = 0; i < n; i++) begin
            step_reports.push_back(window_report(KIND_SENT, s, sent_copy[s], 1'b0, '0,
                                                 i == n - 1));
            s = s + 3'd1;
          end
          next_seq_m = s;
          replay_total += n;
        end else begin
          step_reports.push_back(window_report(KIND_NONE, '0, '0, 1'b0, '0, 1'b1));
        end
      end
      default: begin
        step_reports.push_back(window_report(KIND_NONE, '0, '0, 1'b0, '0, 1'b1));
      end
    endcase
  endfunction

  function automatic void add_row(cmd_t c, logic [PAYLOAD_W-1:0] pay, logic [SEQ_W-1:0] seq,
                                  logic [SEQ_W-1:0] ack, bit typed, result_t want);
    stim_row_t row;
    row.cmd   = c;
    row.pay   = pay;
    row.seq   = seq;
    row.ack   = ack;
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endfunction

  function automatic void check_field(string name, logic [PAYLOAD_W-1:0] want,
                                      logic [PAYLOAD_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
      errors++;
    end
  endfunction

  task automatic idle_gap();
    int gap;
    if (calm_tx) begin
      gap = 0;
    end else if ($urandom_range(0, 11) == 0) begin
      gap = $urandom_range(8, 30);
    end else begin
      gap = $urandom_range(0, 3);
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drive_item(cmd_t c, logic [PAYLOAD_W-1:0] pay, logic [SEQ_W-1:0] rseq,
                            logic [SEQ_W-1:0] rack, bit typed, result_t want);
    in_valid   <= 1'b1;
    in_command <= c;
    in_payload <= pay;
    in_rx_seq  <= rseq;
    in_rx_ack  <= rack;
    @(posedge clk);
    while (!(in_valid && !in_stall)) @(posedge clk);
    accepted_total++;
    predict_window(c, pay, rseq, rack);
    if (typed) begin
      window_reports_q.push_back(want);
    end else begin
      foreach (step_reports[k]) window_reports_q.push_back(step_reports[k]);
    end
    idle_gap();
  endtask

  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if ((rx_cycle / 300) % 4 != 2 && $urandom_range(0, 3) == 0) begin
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 25) : $urandom_range(0, 2);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      checked_total++;
      if (window_reports_q.size() == 0) begin
        $error("unexpected result: kind %0d seq %0d", out_kind, out_frame_seq);
        errors++;
      end else begin
        want = window_reports_q.pop_front();
        check_field("kind", want.kind, out_kind);
        check_field("frame_seq", want.frame_seq, out_frame_seq);
        check_field("frame_ack", want.frame_ack, out_frame_ack);
        check_field("frame_payload", want.frame_payload, out_frame_payload);
        check_field("delivered", want.delivered, out_delivered);
        check_field("delivered_payload", want.delivered_payload, out_delivered_payload);
        check_field("outstanding", want.outstanding, out_outstanding);
        check_field("network_ready", want.network_ready, out_network_ready);
        check_field("last", want.last, out_last);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    cmd_t                 c;
    logic [PAYLOAD_W-1:0] pay;
    logic [SEQ_W-1:0]     rseq;
    logic [SEQ_W-1:0]     rack;
    int                   sel;
    int                   item;

    add_row(CMD_TIMEOUT, 32'h0000_0000, 3'd0, 3'd0, 1'b1,
            fixed_result(KIND_NONE, 3'd0, 3'd0, '0, 1'b0, '0, 3'd0, 1'b1));
    add_row(CMD_CKSUM_ERR, 32'hFFFF_FFFF, 3'd7, 3'd7, 1'b1,
            fixed_result(KIND_NONE, 3'd0, 3'd0, '0, 1'b0, '0, 3'd0, 1'b1));
    add_row(CMD_ARRIVE, 32'hFFFF_FFFF, 3'd0, 3'd7, 1'b1,
            fixed_result(KIND_ARRIVAL, 3'd0, 3'd0, '0, 1'b1, 32'hFFFF_FFFF, 3'd0, 1'b1));
    add_row(CMD_NEW, 32'h0000_0000, 3'd0, 3'd0, 1'b1,
            fixed_result(KIND_SENT, 3'd0, 3'd0, 32'h0000_0000, 1'b0, '0, 3'd1, 1'b1));
    add_row(CMD_NEW, 32'hFFFF_FFFF, 3'd7, 3'd7, 1'b1,
            fixed_result(KIND_SENT, 3'd1, 3'd0, 32'hFFFF_FFFF, 1'b0, '0, 3'd2, 1'b1));
    add_row(CMD_NEW, 32'hA5A5_A5A5, 3'd0, 3'd0, 1'b0, '0);
    add_row(CMD_NEW, 32'h5A5A_5A5A, 3'd0, 3'd0, 1'b0, '0);
    add_row(CMD_NEW, 32'h1234_5678, 3'd0, 3'd0, 1'b0, '0);
    add_row(CMD_NEW, 32'h8000_0000, 3'd0, 3'd0, 1'b0, '0);
    add_row(CMD_NEW, 32'h0000_0001, 3'd0, 3'd0, 1'b0, '0);
    add_row(CMD_NEW, 32'hDEAD_BEEF, 3'd0, 3'd0, 1'b1,
            fixed_result(KIND_REFUSED, 3'd0, 3'd0, '0, 1'b0, '0, 3'd7, 1'b0));
    add_row(CMD_TIMEOUT, 32'h0000_0000, 3'd0, 3'd0, 1'b0, '0);
    add_row(CMD_ARRIVE, 32'h0F0F_0F0F, 3'd5, 3'd7, 1'b0, '0);
    add_row(CMD_ARRIVE, 32'hF0F0_F0F0, 3'd1, 3'd2, 1'b0, '0);
    add_row(CMD_ARRIVE, 32'h0000_0000, 3'd3, 3'd3, 1'b0, '0);
    add_row(CMD_NEW, 32'h7FFF_FFFF, 3'd0, 3'd0, 1'b0, '0);
    add_row(CMD_NEW, 32'hFFFF_0000, 3'd0, 3'd0, 1'b0, '0);
    add_row(CMD_TIMEOUT, 32'hFFFF_FFFF, 3'd7, 3'd7, 1'b0, '0);
    add_row(CMD_ARRIVE, 32'h0000_FFFF, 3'd2, 3'd0, 1'b0, '0);
    add_row(CMD_TIMEOUT, 32'h0000_0000, 3'd0, 3'd0, 1'b1,
            fixed_result(KIND_NONE, 3'd0, 3'd0, '0, 1'b0, '0, 3'd0, 1'b1));
    add_row(CMD_ARRIVE, 32'h3C3C_3C3C, 3'd6, 3'd5, 1'b0, '0);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      drive_item(directed_rows[i].cmd, directed_rows[i].pay, directed_rows[i].seq,
                 directed_rows[i].ack, directed_rows[i].typed, directed_rows[i].want);
    end

    for (item = 0; item < RANDOM_ITEMS; item++) begin
      calm_tx = (item >= 180 && item < 250);
      sel = $urandom_range(0, 99);
      case ($urandom_range(0, 15))
        0:       pay = 32'h0000_0000;
        1:       pay = 32'hFFFF_FFFF;
        default: pay = $urandom;
      endcase
      rseq = 3'($urandom_range(0, 7));
      rack = 3'($urandom_range(0, 7));
      if (sel < 40) begin
        c = CMD_NEW;
      end else if (sel < 75) begin
        c = CMD_ARRIVE;
        if ($urandom_range(0, 3) != 0) begin
          rseq = exp_rx_m;
        end
        if (outst_m != 0 && $urandom_range(0, 3) != 0) begin
          rack = oldest_m + 3'($urandom_range(0, outst_m - 1));
        end
      end else if (sel < 85) begin
        c = CMD_CKSUM_ERR;
      end else begin
        c = CMD_TIMEOUT;
      end
      drive_item(c, pay, rseq, rack, 1'b0, '0);
    end

    in_valid <= 1'b0;
    while (window_reports_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d transactions and %0d checked results: %0d replayed frames,",
             accepted_total, checked_total, replay_total);
    $display("%0d refused packets and %0d in-order deliveries.", refused_total,
             delivered_total);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/gbn_pkg.sv
rtl/gbn_send_store.sv
rtl/gbn_out_reg.sv
rtl/go_back_n_window_engine_core.sv
rtl/gbn_core_checker.sv
tb/tb_go_back_n_window_engine_core.sv
